>>> rtl/sfb_pkg.sv
// sfb_pkg: widths, register indexes and transaction types of the seam feather blend.
// No dependencies; imported by seam_feather_blend_core and sfb_checker.
`timescale 1ns / 1ps

package sfb_pkg;

	localparam int COL_W      = 12;
	localparam int PIX_W      = 8;
	localparam int WID_W      = 13;
	// p*(W-k) + t*k is at most 255*8191 < 2**21
	localparam int NUM_W      = 21;
	// one quotient bit per divide stage; the quotient never exceeds 255
	localparam int DIV_STAGES = PIX_W;
	// start edge to the cycle that carries done
	localparam int LATENCY    = 3 + DIV_STAGES;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_START   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_WIDTH = 2'd1;

	localparam logic [WID_W-1:0] REF_WIDTH_RESET = 13'd4096;

	typedef logic [2:0][PIX_W-1:0] rgb_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [PIX_W-1:0] ref_red;
		logic [PIX_W-1:0] ref_green;
		logic [PIX_W-1:0] ref_blue;
		logic [PIX_W-1:0] warp_red;
		logic [PIX_W-1:0] warp_green;
		logic [PIX_W-1:0] warp_blue;
	} sfb_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
	} sfb_out_t;

endpackage

>>> rtl/seam_feather_blend_core.sv
// seam_feather_blend_core: linear feather blend of a reference and a warped RGB pixel.
// Depends on sfb_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel: drive pixels and raise start; a transaction is taken at each
//   rising edge with start high and busy low. busy is always low, so one pixel
//   can be taken every clock.
//   Result channel: done is high for one cycle with the blended pixel on
//   blended once the accepted pixel has left the divide stages. Results come out in
//   input order, one per input. The receiver cannot stall; it must take done.
//   Throughput: one pixel per clock, set by the fully pipelined datapath:
//   column decode, products, sum, then eight restoring-divide stages (one
//   quotient bit each) that divide by the overlap width.
//   Config: cfg_we with cfg_index 0 writes overlap_start, 1 writes
//   reference_width; other indexes are ignored. Write only while no
//   transaction is in flight.
//   Reset: arst_n clears the pipeline valids and sets overlap_start to 0 and
//   reference_width to 4096. Pass-through pixels ride the divider with a
//   divisor of one.
module seam_feather_blend_core #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  sfb_pkg::sfb_in_t                pixels,
	output logic                            done,
	output sfb_pkg::sfb_out_t               blended,
	input  logic                            cfg_we,
	input  logic [sfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfb_pkg::WID_W-1:0]       cfg_data
);
	import sfb_pkg::*;

	localparam int WID_MAX = (1 << WID_W) - 1;
	localparam int CLAMP   = (MAX_WIDTH < WID_MAX) ? MAX_WIDTH : WID_MAX;
	localparam logic [WID_W-1:0] WIDTH_CLAMP = WID_W'(CLAMP);

	typedef struct packed {
		logic [WID_W-1:0]           w;
		rgb_t                       quo;
		logic [2:0][NUM_W-1:0]      rem;
	} div_t;

	// configuration
	logic [COL_W-1:0] ovl_start_q;
	logic [WID_W-1:0] ref_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_start_q <= '0;
			ref_width_q <= REF_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OVERLAP_START:   ovl_start_q <= cfg_data[COL_W-1:0];
				REG_REFERENCE_WIDTH: ref_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// column decode: pass-through cases become W=1 with k selecting ref or warp
	logic [WID_W-1:0] width_eff, col_ext, start_ext;
	logic [WID_W-1:0] w_in, k_in, wmk_in;
	logic             warp_black, ref_black;
	rgb_t             ref_in, warp_in;

	assign width_eff  = (ref_width_q > WIDTH_CLAMP) ? WIDTH_CLAMP : ref_width_q;
	assign col_ext    = {1'b0, pixels.column};
	assign start_ext  = {1'b0, ovl_start_q};
	assign ref_in     = {pixels.ref_blue, pixels.ref_green, pixels.ref_red};
	assign warp_in    = {pixels.warp_blue, pixels.warp_green, pixels.warp_red};
	assign warp_black = ~|warp_in;
	assign ref_black  = ~|ref_in;

	always_comb begin
		w_in   = WID_W'(1);
		k_in   = '0;
		wmk_in = WID_W'(1);
		if (col_ext >= width_eff) begin
			k_in   = WID_W'(1);
			wmk_in = '0;
		end else if (pixels.column < ovl_start_q) begin
			k_in   = '0;
		end else if (warp_black) begin
			k_in   = '0;
		end else if (ref_black) begin
			k_in   = WID_W'(1);
			wmk_in = '0;
		end else begin
			w_in   = width_eff - start_ext;
			k_in   = col_ext - start_ext;
			wmk_in = width_eff - col_ext;
		end
	end

	// stage 1: decoded weights
	logic             v_s1;
	logic [WID_W-1:0] w_s1, k_s1, wmk_s1;
	rgb_t             ref_s1, warp_s1;

	// stage 2: products
	logic                  v_s2;
	logic [WID_W-1:0]      w_s2;
	logic [2:0][NUM_W-1:0] pw_s2, tk_s2;

	// stage 3: numerators
	logic                  v_s3;
	logic [WID_W-1:0]      w_s3;
	logic [2:0][NUM_W-1:0] num_s3;

	// divide stages; div_s[i] is pipeline stage 4+i
	div_t                  div_s   [DIV_STAGES];
	logic [DIV_STAGES-1:0] div_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		w_s1    <= w_in;
		k_s1    <= k_in;
		wmk_s1  <= wmk_in;
		ref_s1  <= ref_in;
		warp_s1 <= warp_in;
		w_s2    <= w_s1;
		w_s3    <= w_s2;
		for (int c = 0; c < 3; c++) begin
			pw_s2[c]  <= NUM_W'(ref_s1[c]) * NUM_W'(wmk_s1);
			tk_s2[c]  <= NUM_W'(warp_s1[c]) * NUM_W'(k_s1);
			num_s3[c] <= pw_s2[c] + tk_s2[c];
		end
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		localparam int SH = DIV_STAGES - 1 - i;
		div_t             din, dnext;
		logic             vin;
		logic [NUM_W-1:0] dsor;

		if (i == 0) begin : g_first
			assign din.w   = w_s3;
			assign din.quo = '0;
			assign din.rem = num_s3;
			assign vin     = v_s3;
		end else begin : g_next
			assign din = div_s[i-1];
			assign vin = div_v_s[i-1];
		end

		assign dsor = NUM_W'(din.w) << SH;

		always_comb begin
			dnext = din;
			for (int c = 0; c < 3; c++) begin
				if (din.rem[c] >= dsor) begin
					dnext.rem[c]     = din.rem[c] - dsor;
					dnext.quo[c][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[i] <= 1'b0;
			end else begin
				div_v_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			div_s[i] <= dnext;
		end
	end

	assign done              = div_v_s[DIV_STAGES-1];
	assign blended.out_red   = div_s[DIV_STAGES-1].quo[0];
	assign blended.out_green = div_s[DIV_STAGES-1].quo[1];
	assign blended.out_blue  = div_s[DIV_STAGES-1].quo[2];

endmodule

>>> rtl/sfb_checker.sv
// sfb_checker: port-level assertions for seam_feather_blend_core, with its bind.
// Depends on sfb_pkg.
`timescale 1ns / 1ps

module sfb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input sfb_pkg::sfb_in_t              pixels,
	input logic                          done,
	input sfb_pkg::sfb_out_t             blended
);
	import sfb_pkg::*;

	logic accept;
	logic same_pix;
	assign accept   = start && !busy;
	assign same_pix = (pixels.ref_red == pixels.warp_red) &&
	                  (pixels.ref_green == pixels.warp_green) &&
	                  (pixels.ref_blue == pixels.warp_blue);

	function automatic logic in_span(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
	                                 logic [PIX_W-1:0] o);
		logic [PIX_W-1:0] lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (o >= lo) && (o <= hi);
	endfunction

	// every transaction produces exactly one strobe at fixed latency
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted transaction gave no result");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching transaction");

	// blending identical pixels returns that pixel in every region
	a_same_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && same_pix) |-> ##LATENCY
			((blended.out_red == $past(pixels.ref_red, LATENCY)) &&
			 (blended.out_green == $past(pixels.ref_green, LATENCY)) &&
			 (blended.out_blue == $past(pixels.ref_blue, LATENCY))))
		else $error("identical inputs not reproduced");

	// a cross-fade stays between its two sources
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY
			(in_span($past(pixels.ref_red, LATENCY), $past(pixels.warp_red, LATENCY),
			         blended.out_red) &&
			 in_span($past(pixels.ref_green, LATENCY), $past(pixels.warp_green, LATENCY),
			         blended.out_green) &&
			 in_span($past(pixels.ref_blue, LATENCY), $past(pixels.warp_blue, LATENCY),
			         blended.out_blue)))
		else $error("blended channel outside source range");

endmodule

bind seam_feather_blend_core sfb_checker u_sfb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.pixels  (pixels),
	.done    (done),
	.blended (blended)
);
